// ===== hw/rtl/tadc_pkg.sv =====
// Package for the thermistor sample to temperature pipeline.
// Holds widths, fixed-point constants, stage counts and register indexes.
// No dependencies; every other RTL file uses it by scoped names.
`default_nettype none

package tadc_pkg;

    localparam int ADC_BITS     = 10;
    localparam int IN_TDATA_W   = ((ADC_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = 16;

    // Log2 unit: integer operand up to 2^17 - 1, result in Q28 with a 5-bit integer part.
    localparam int LOG_IN_W     = 17;
    localparam int FRAC_BITS    = 28;
    localparam int LOG_STEPS    = FRAC_BITS;
    localparam int LOG_W        = 5 + FRAC_BITS;
    localparam int LOG_STAGES   = LOG_STEPS + 1;

    localparam logic [27:0] LN2_Q28      = 28'd186065279;
    localparam logic [34:0] INV_T25_Q28  = 35'd900337;
    localparam logic [48:0] TWENTY_Q28   = 49'd5368709120;
    localparam logic [48:0] KOFF_HALF    = 49'd5463;
    localparam logic [17:0] RECIP5       = 18'd209716;
    localparam int          RECIP5_SHIFT = 20;

    localparam int DIV1_BITS    = 33;
    localparam int DIV2_BITS    = 17;

    // Stages: log unit, sum, two product stages, divider one, x, n, overflow check,
    // divider two, Celsius, times nine, divide by five, final select.
    localparam int PIPE_DEPTH   = LOG_STAGES + 3 + DIV1_BITS + 3 + DIV2_BITS + 4;

    localparam int CFG_IDX_W    = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_F  = 3'd3;

    localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [15:0] TEMP_MIN = -16'sh8000;

endpackage

`default_nettype wire

// ===== hw/rtl/tadc_log2.sv =====
// Pipelined log2 of a positive integer in Q28, by normalization and repeated squaring.
// One normalize stage and one squaring stage per fraction bit; uses tadc_pkg.
`default_nettype none

module tadc_log2 (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [tadc_pkg::LOG_IN_W-1:0] v,
    output logic      [tadc_pkg::LOG_W-1:0]    log_q
);

    logic [30:0] m_reg    [0:tadc_pkg::LOG_STEPS];
    logic [27:0] frac_reg [0:tadc_pkg::LOG_STEPS];
    logic [4:0]  e_reg    [0:tadc_pkg::LOG_STEPS];

    logic [tadc_pkg::LOG_IN_W-1:0] vv;
    logic [4:0]                    e_next;
    logic [30:0]                   m_next;

    // Zero reads as one; e is the position of the leading one.
    always_comb
    begin
        vv = (v == '0) ? tadc_pkg::LOG_IN_W'(1) : v;
        e_next = 5'd0;
        for (int i = 1; i < tadc_pkg::LOG_IN_W; i++)
        begin
            if (vv[i])
            begin
                e_next = 5'(i);
            end
        end
        m_next = 31'(47'(vv) << (5'd30 - e_next));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= m_next;
            frac_reg[0] <= '0;
            e_reg[0]    <= e_next;
        end
    end

    for (genvar k = 1; k <= tadc_pkg::LOG_STEPS; k++)
    begin : g_sq
        logic [61:0] sq;
        logic [31:0] t;
        assign sq = 62'(m_reg[k-1]) * 62'(m_reg[k-1]);
        assign t  = sq[61:30];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k]    <= t[31] ? t[31:1] : t[30:0];
                frac_reg[k] <= {frac_reg[k-1][26:0], t[31]};
                e_reg[k]    <= e_reg[k-1];
            end
        end
    end

    assign log_q = {e_reg[tadc_pkg::LOG_STEPS], frac_reg[tadc_pkg::LOG_STEPS]};

endmodule

`default_nettype wire

// ===== hw/rtl/thermistor_adc_to_temperature_top.sv =====
// Top level: thermistor divider sample to tenths of a degree, beta equation in fixed point.
// Depends on tadc_pkg and tadc_log2.
// Channels: s_axis carries samples, m_axis carries results, cfg writes registers.
//
// Usage
//   A sample is a transfer on s_axis (tdata[9:0] = adc_sample). Its result leaves as a
//   transfer on m_axis: tdata[15:0] = temp_tenths (two's complement), tuser = out_of_range.
//   Registers are written over the cfg channel (index 0 bias_ohms, 1 nominal_ohms,
//   2 beta_kelvin, 3 unit_fahrenheit; other indexes are ignored); cfg_ready is always high.
//   Write registers only while no sample is in flight.
//   One sample per cycle is accepted while the output is not stalled; the rate is set by
//   the single shared enable of the 89-stage pipeline, whose depth comes from the 28 squaring
//   stages of the log units and the two bit-per-stage dividers (33 and 17 stages).
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated. Empty slots are not squeezed out:
//   the pipeline moves as a whole whenever the output register is empty or being taken.
//   Reset clears all valid bits and loads the register defaults (217, 3075, 3820,
//   Fahrenheit).
`default_nettype none

module thermistor_adc_to_temperature_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [tadc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [9:0] adc_sample
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [tadc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [15:0] temp_tenths
    output logic                                    m_axis_tuser,   // [0] out_of_range
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tadc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [15:0]                        cfg_data
);

    localparam int LAST = tadc_pkg::PIPE_DEPTH - 1;

    logic [15:0] bias_reg;
    logic [15:0] nominal_reg;
    logic [15:0] beta_reg;
    logic        unit_f_reg;

    logic [tadc_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [tadc_pkg::PIPE_DEPTH-1:0] zero_reg;
    logic                            adv;

    logic [tadc_pkg::ADC_BITS-1:0]   adc;
    logic [tadc_pkg::ADC_BITS:0]     rest;
    logic [15:0]                     bias_eff;
    logic [15:0]                     nom_eff;
    logic [15:0]                     beta_eff;
    logic [tadc_pkg::LOG_W-1:0]      lg_bias;
    logic [tadc_pkg::LOG_W-1:0]      lg_rest;
    logic [tadc_pkg::LOG_W-1:0]      lg_adc;
    logic [tadc_pkg::LOG_W-1:0]      lg_nom;

    assign adv           = !vld_reg[LAST] || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = vld_reg[LAST];

    assign adc      = s_axis_tdata[tadc_pkg::ADC_BITS-1:0];
    assign rest     = (tadc_pkg::ADC_BITS + 1)'(1 << tadc_pkg::ADC_BITS) - {1'b0, adc};
    assign bias_eff = (bias_reg == '0) ? 16'd1 : bias_reg;
    assign nom_eff  = (nominal_reg == '0) ? 16'd1 : nominal_reg;
    assign beta_eff = (beta_reg == '0) ? 16'd1 : beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg    <= 16'd217;
            nominal_reg <= 16'd3075;
            beta_reg    <= 16'd3820;
            unit_f_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tadc_pkg::CFG_BIAS:    bias_reg    <= cfg_data;
                tadc_pkg::CFG_NOMINAL: nominal_reg <= cfg_data;
                tadc_pkg::CFG_BETA:    beta_reg    <= cfg_data;
                tadc_pkg::CFG_UNIT_F:  unit_f_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg <= {zero_reg[LAST-1:0], (adc == '0)};
        end
    end

    // Four log lanes; user keeps registers stable while samples are in flight, unchecked.
    tadc_log2 u_log_bias (.clk(clk), .en(adv), .v(17'(bias_eff)), .log_q(lg_bias));
    tadc_log2 u_log_rest (.clk(clk), .en(adv), .v(17'(rest)),     .log_q(lg_rest));
    tadc_log2 u_log_adc  (.clk(clk), .en(adv), .v(17'(adc)),      .log_q(lg_adc));
    tadc_log2 u_log_nom  (.clk(clk), .en(adv), .v(17'(nom_eff)),  .log_q(lg_nom));

    // Log sum, kept as sign and magnitude.
    logic signed [35:0] l2_next;
    logic [32:0]        l2_mag_reg;
    logic               l2_neg_reg;

    assign l2_next = 36'(lg_bias) + 36'(lg_rest) - 36'(lg_adc) - 36'(lg_nom);

    // Scale by ln 2 in two partial products.
    logic [45:0] pp_lo_reg;
    logic [42:0] pp_hi_reg;
    logic        pp_neg_reg;
    logic [60:0] prod;

    assign prod = {pp_hi_reg, 18'd0} + 61'(pp_lo_reg);

    // Divider one: ln / beta, one quotient bit per stage.
    logic [32:0] d1_dvd_reg [0:tadc_pkg::DIV1_BITS];
    logic [15:0] d1_rem_reg [0:tadc_pkg::DIV1_BITS];
    logic [32:0] d1_q_reg   [0:tadc_pkg::DIV1_BITS];
    logic        d1_neg_reg [0:tadc_pkg::DIV1_BITS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l2_neg_reg    <= l2_next[35];
            l2_mag_reg    <= 33'(l2_next[35] ? -l2_next : l2_next);
            pp_lo_reg     <= 46'(l2_mag_reg[17:0]) * 46'(tadc_pkg::LN2_Q28);
            pp_hi_reg     <= 43'(l2_mag_reg[32:18]) * 43'(tadc_pkg::LN2_Q28);
            pp_neg_reg    <= l2_neg_reg;
            d1_dvd_reg[0] <= prod[60:28];
            d1_rem_reg[0] <= '0;
            d1_q_reg[0]   <= '0;
            d1_neg_reg[0] <= pp_neg_reg;
        end
    end

    for (genvar j = 1; j <= tadc_pkg::DIV1_BITS; j++)
    begin : g_div1
        logic [16:0] r2;
        logic        take;
        assign r2   = {d1_rem_reg[j-1], d1_dvd_reg[j-1][32]};
        assign take = r2 >= {1'b0, beta_eff};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d1_rem_reg[j] <= take ? 16'(r2 - {1'b0, beta_eff}) : r2[15:0];
                d1_dvd_reg[j] <= {d1_dvd_reg[j-1][31:0], 1'b0};
                d1_q_reg[j]   <= {d1_q_reg[j-1][31:0], take};
                d1_neg_reg[j] <= d1_neg_reg[j-1];
            end
        end
    end

    // x = 1/T in Q28, then n = 20*2^28 - 5463*x and d = 2*x.
    logic [32:0]        q1;
    logic signed [34:0] x_next;
    logic signed [34:0] x_reg;
    logic               x_hot_reg;
    logic signed [48:0] n_next;
    logic [47:0]        n_mag_reg;
    logic               n_neg_reg;
    logic [34:0]        dd_reg;
    logic               hot_f_reg;

    assign q1     = d1_q_reg[tadc_pkg::DIV1_BITS];
    assign x_next = (d1_neg_reg[tadc_pkg::DIV1_BITS] ? -35'(q1) : 35'(q1))
                    + signed'(tadc_pkg::INV_T25_Q28);
    assign n_next = signed'(tadc_pkg::TWENTY_Q28) - 49'(x_reg) * signed'(tadc_pkg::KOFF_HALF);

    // Divider two: |n| / d, 17 quotient bits after an overflow check.
    logic [47:0] d2_rem_reg [0:tadc_pkg::DIV2_BITS];
    logic [34:0] d2_d_reg   [0:tadc_pkg::DIV2_BITS];
    logic [16:0] d2_q_reg   [0:tadc_pkg::DIV2_BITS];
    logic        d2_neg_reg [0:tadc_pkg::DIV2_BITS];
    logic        d2_hot_reg [0:tadc_pkg::DIV2_BITS];
    logic        d2_ovf_reg [0:tadc_pkg::DIV2_BITS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg         <= x_next;
            x_hot_reg     <= x_next[34] || (x_next == '0);
            n_neg_reg     <= n_next[48];
            n_mag_reg     <= 48'(n_next[48] ? -n_next : n_next);
            dd_reg        <= {x_reg[33:0], 1'b0};
            hot_f_reg     <= x_hot_reg;
            d2_rem_reg[0] <= n_mag_reg;
            d2_d_reg[0]   <= dd_reg;
            d2_q_reg[0]   <= '0;
            d2_neg_reg[0] <= n_neg_reg;
            d2_hot_reg[0] <= hot_f_reg;
            d2_ovf_reg[0] <= 52'(n_mag_reg) >= (52'(dd_reg) << tadc_pkg::DIV2_BITS);
        end
    end

    for (genvar j = 1; j <= tadc_pkg::DIV2_BITS; j++)
    begin : g_div2
        logic [51:0] cmp;
        logic        take;
        assign cmp  = 52'(d2_d_reg[j-1]) << (tadc_pkg::DIV2_BITS - j);
        assign take = 52'(d2_rem_reg[j-1]) >= cmp;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d2_rem_reg[j] <= take ? d2_rem_reg[j-1] - cmp[47:0] : d2_rem_reg[j-1];
                d2_d_reg[j]   <= d2_d_reg[j-1];
                d2_q_reg[j]   <= {d2_q_reg[j-1][15:0], take};
                d2_neg_reg[j] <= d2_neg_reg[j-1];
                d2_hot_reg[j] <= d2_hot_reg[j-1];
                d2_ovf_reg[j] <= d2_ovf_reg[j-1];
            end
        end
    end

    // Celsius with saturation.
    logic [16:0]        q2;
    logic               q_neg;
    logic signed [15:0] c_next;
    logic               c_flag_next;
    logic signed [15:0] c_reg  [0:2];
    logic               cf_reg [0:2];
    logic               hot_reg [0:2];

    assign q2    = d2_q_reg[tadc_pkg::DIV2_BITS];
    assign q_neg = d2_neg_reg[tadc_pkg::DIV2_BITS];

    always_comb
    begin
        c_next      = 16'(q2);
        c_flag_next = 1'b0;
        if (d2_hot_reg[tadc_pkg::DIV2_BITS])
        begin
            c_next      = tadc_pkg::TEMP_MAX;
            c_flag_next = 1'b1;
        end
        else if (q_neg)
        begin
            if (d2_ovf_reg[tadc_pkg::DIV2_BITS] || (q2 > 17'd32768))
            begin
                c_next      = tadc_pkg::TEMP_MIN;
                c_flag_next = 1'b1;
            end
            else
            begin
                c_next = 16'(-q2);
            end
        end
        else if (d2_ovf_reg[tadc_pkg::DIV2_BITS] || (q2 > 17'd32767))
        begin
            c_next      = tadc_pkg::TEMP_MAX;
            c_flag_next = 1'b1;
        end
    end

    // Fahrenheit: times nine, divide by five on the magnitude, add 320.
    logic signed [19:0] v9;
    logic [18:0]        v9_mag_reg;
    logic               v9_neg_reg;
    logic [36:0]        r5;
    logic [16:0]        f5_reg;
    logic               f5_neg_reg;
    logic signed [17:0] f_sum;
    logic signed [15:0] f_val;
    logic               f_sat;
    logic signed [15:0] out_next;
    logic               flag_next;
    logic [15:0]        tdata_reg;
    logic               tuser_reg;

    assign v9    = 20'(c_reg[0]) * 20'sd9;
    assign r5    = 37'(v9_mag_reg) * 37'(tadc_pkg::RECIP5);
    assign f_sum = (f5_neg_reg ? -18'(f5_reg) : 18'(f5_reg)) + 18'sd320;

    always_comb
    begin
        f_val = 16'(f_sum);
        f_sat = 1'b0;
        if (f_sum > 18'sd32767)
        begin
            f_val = tadc_pkg::TEMP_MAX;
            f_sat = 1'b1;
        end
        else if (f_sum < -18'sd32768)
        begin
            f_val = tadc_pkg::TEMP_MIN;
            f_sat = 1'b1;
        end

        if (zero_reg[LAST-1])
        begin
            out_next  = tadc_pkg::TEMP_MIN;
            flag_next = 1'b1;
        end
        else if (hot_reg[2])
        begin
            out_next  = tadc_pkg::TEMP_MAX;
            flag_next = 1'b1;
        end
        else if (unit_f_reg)
        begin
            out_next  = f_val;
            flag_next = cf_reg[2] || f_sat;
        end
        else
        begin
            out_next  = c_reg[2];
            flag_next = cf_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg[0]   <= c_next;
            cf_reg[0]  <= c_flag_next;
            hot_reg[0] <= d2_hot_reg[tadc_pkg::DIV2_BITS];
            for (int i = 1; i < 3; i++)
            begin
                c_reg[i]   <= c_reg[i-1];
                cf_reg[i]  <= cf_reg[i-1];
                hot_reg[i] <= hot_reg[i-1];
            end
            v9_neg_reg <= v9[19];
            v9_mag_reg <= 19'(v9[19] ? -v9 : v9);
            f5_neg_reg <= v9_neg_reg;
            f5_reg     <= r5[tadc_pkg::RECIP5_SHIFT +: 17];
            tdata_reg  <= out_next;
            tuser_reg  <= flag_next;
        end
    end

    assign m_axis_tdata = tdata_reg;
    assign m_axis_tuser = tuser_reg;

`ifndef ASSERT_OFF
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && zero_reg[LAST]) |->
        (m_axis_tdata == 16'h8000) && m_axis_tuser)
        else $error("zero sample did not give the saturated low result");

    a_hot_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[LAST-1] && !zero_reg[LAST-1] && hot_reg[2]) |=>
        (m_axis_tdata == 16'h7FFF) && m_axis_tuser)
        else $error("non-positive 1/T did not give the saturated high result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for thermistor_adc_to_temperature_top.
// Drives samples with random gaps and stalls, predicts each temperature in fixed point.
// Depends on tadc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY = 89;

    typedef struct packed {
        logic [15:0] temp;
        logic        oor;
    } temp_result_t;

    typedef struct {
        logic [9:0]  adc;
        logic        has_known;
        logic [15:0] known_temp;
        logic        known_oor;
    } sample_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [tadc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;    // [9:0] adc_sample
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [tadc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;         // [15:0] temp_tenths
    logic m_axis_tuser;                                     // [0] out_of_range
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [tadc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Predictor copy of the registers.
    logic [15:0] bias_reg = 16'd217;
    logic [15:0] nominal_reg = 16'd3075;
    logic [15:0] beta_reg = 16'd3820;
    logic        fahr_reg = 1'b1;

    temp_result_t pending_temps[$];
    int failures = 0;
    int results_seen = 0;
    int samples_sent = 0;
    bit long_hold = 1'b0;

    thermistor_adc_to_temperature_top DUT (.*);

    always #6 clk = ~clk;

    function automatic longint log2_fixed(int unsigned v);
        int unsigned e;
        longint unsigned m;
        longint unsigned frac;
        e = 0;
        frac = 0;
        if (v == 0)
            v = 1;
        while (e < 16 && (v >> (e + 1)) != 0)
            e++;
        m = longint'(v) << (30 - e);
        for (int i = 0; i < 28; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'((longint'(e) << 28) | frac);
    endfunction

    function automatic longint sat16(longint v, inout logic flag);
        if (v > 32767)
        begin
            flag = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            flag = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic temp_result_t predict_temperature(logic [9:0] adc);
        temp_result_t r;
        int unsigned bias, nom, beta;
        longint l2, ln_val, x, n, t;
        logic flag;
        bias = (bias_reg == 0) ? 1 : bias_reg;
        nom = (nominal_reg == 0) ? 1 : nominal_reg;
        beta = (beta_reg == 0) ? 1 : beta_reg;
        flag = 1'b0;
        if (adc == 0)
        begin
            t = -32768;
            flag = 1'b1;
        end
        else
        begin
            l2 = log2_fixed(bias) + log2_fixed(1024 - adc) - log2_fixed(adc) - log2_fixed(nom);
            ln_val = (l2 * 64'sd186065279) / (64'sd1 << 28);
            x = ln_val / longint'(beta) + 64'sd900337;
            if (x <= 0)
            begin
                t = 32767;
                flag = 1'b1;
            end
            else
            begin
                n = 64'sd20 * (64'sd1 << 28) - 64'sd5463 * x;
                t = sat16(n / (2 * x), flag);
                if (fahr_reg)
                    t = sat16(t * 9 / 5 + 320, flag);
            end
        end
        r.temp = t[15:0];
        r.oor = flag;
        return r;
    endfunction

    task automatic write_reg(logic [tadc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            tadc_pkg::CFG_BIAS:    bias_reg = val;
            tadc_pkg::CFG_NOMINAL: nominal_reg = val;
            tadc_pkg::CFG_BETA:    beta_reg = val;
            tadc_pkg::CFG_UNIT_F:  fahr_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] b, logic [15:0] nm, logic [15:0] bt, logic f);
        write_reg(tadc_pkg::CFG_BIAS, b);
        write_reg(tadc_pkg::CFG_NOMINAL, nm);
        write_reg(tadc_pkg::CFG_BETA, bt);
        write_reg(tadc_pkg::CFG_UNIT_F, {15'd0, f});
    endtask

    task automatic wait_drained();
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Offers one sample, with a random gap before it when gaps is set; the expectation is queued on the transfer.
    task automatic send_sample(logic [9:0] adc, bit gaps);
        int gap;
        if (gaps)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(tadc_pkg::IN_TDATA_W - 10){1'b0}}, adc};
        do @(posedge clk); while (!s_axis_tready);
        pending_temps.push_back(predict_temperature(adc));
        samples_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0)
                    ? (($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 3))
                    : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        temp_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_temps.size() == 0)
            begin
                $error("unexpected result temp_tenths=%0d", $signed(m_axis_tdata));
                failures++;
            end
            else
            begin
                exp_r = pending_temps.pop_front();
                if (m_axis_tdata !== exp_r.temp)
                begin
                    $error("temp_tenths expected %0d actual %0d",
                           $signed(exp_r.temp), $signed(m_axis_tdata));
                    failures++;
                end
                if (m_axis_tuser !== exp_r.oor)
                begin
                    $error("out_of_range expected %0b actual %0b", exp_r.oor, m_axis_tuser);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        sample_row_t rows[$];
        temp_result_t got;
        logic [9:0] adc;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset settings; known values only for the zero sample.
        rows = '{
            '{10'd0, 1'b1, 16'h8000, 1'b1},
            '{10'd1, 1'b0, 16'd0, 1'b0},
            '{10'd2, 1'b0, 16'd0, 1'b0},
            '{10'd100, 1'b0, 16'd0, 1'b0},
            '{10'd341, 1'b0, 16'd0, 1'b0},
            '{10'd512, 1'b0, 16'd0, 1'b0},
            '{10'd682, 1'b0, 16'd0, 1'b0},
            '{10'd900, 1'b0, 16'd0, 1'b0},
            '{10'd1022, 1'b0, 16'd0, 1'b0},
            '{10'd1023, 1'b0, 16'd0, 1'b0},
            '{10'h155, 1'b0, 16'd0, 1'b0},
            '{10'h2AA, 1'b0, 16'd0, 1'b0}
        };
        foreach (rows[i])
        begin
            if (rows[i].has_known)
            begin
                got = predict_temperature(rows[i].adc);
                if (got.temp !== rows[i].known_temp || got.oor !== rows[i].known_oor)
                begin
                    $error("zero-sample prediction expected %h actual %h",
                           rows[i].known_temp, got.temp);
                    failures++;
                end
            end
            send_sample(rows[i].adc, 1'b1);
        end
        stop_sending();
        wait_drained();

        // Extreme settings: zero registers treated as one, huge ratios, unit change.
        configure(16'd0, 16'd65535, 16'd1, 1'b0);
        foreach (rows[i])
            send_sample(rows[i].adc, 1'b0);
        stop_sending();
        wait_drained();
        configure(16'd65535, 16'd1, 16'd0, 1'b1);
        foreach (rows[i])
            send_sample(rows[i].adc, 1'b1);
        stop_sending();
        wait_drained();
        write_reg(3'd7, 16'hFFFF);    // out-of-list index, ignored

        // Random phases: realistic settings most of the time, wild ones now and then.
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase % 3 == 2)
                configure(16'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom_range(0, 1)));
            else
                configure(16'($urandom_range(100, 20000)), 16'($urandom_range(500, 50000)),
                          16'($urandom_range(2500, 5000)), 1'($urandom_range(0, 1)));
            if (phase == 1)
                long_hold = 1'b1;
            for (int k = 0; k < 70; k++)
            begin
                case ($urandom_range(0, 9))
                    0: adc = 10'($urandom_range(0, 3));
                    1: adc = 10'($urandom_range(1020, 1023));
                    default: adc = 10'($urandom);
                endcase
                send_sample(adc, phase != 1);
            end
            stop_sending();
            wait_drained();
        end

        $display("Covered %0d samples, %0d results, over reset, extreme and random settings.",
                 samples_sent, results_seen);
        if (failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tadc_pkg.sv
hw/rtl/tadc_log2.sv
hw/rtl/thermistor_adc_to_temperature_top.sv
tb/sv/tb.sv
